// ----- rtl/mrsi_pkg.sv -----
`timescale 1ns / 1ps
// shared types and constants for the music register stream interpreter
// no dependencies; imported by every module of the block

package mrsi_pkg;

	localparam int QUEUE_DEPTH = 2;

	// command byte boundaries
	localparam logic [7:0] CMD_EXT    = 8'h40;
	localparam logic [7:0] CMD_END    = 8'h80;
	localparam logic [7:0] CNT_MASK   = 8'h3f;
	localparam logic [7:0] DELAY_MASK = 8'h7f;

	// request codes on the input beat
	localparam logic [1:0] REQ_TICK  = 2'd0;
	localparam logic [1:0] REQ_BYTE  = 2'd1;
	localparam logic [1:0] REQ_START = 2'd2;

	typedef struct packed {
		logic [1:0] req_type;
		logic [7:0] in_byte;
	} in_item_t;

	typedef struct packed {
		logic       write_valid;
		logic       write_chip;
		logic [7:0] write_reg;
		logic [7:0] write_value;
		logic       want_bytes;
		logic       is_playing;
		logic       byte_ignored;
	} out_item_t;

	localparam logic CHIP_PSG = 1'b0;
	localparam logic CHIP_YM  = 1'b1;

	typedef enum logic [1:0] {
		OP_TICK,
		OP_BYTE,
		OP_START,
		OP_NOP
	} op_t;

	// class of a byte when it is read as a command
	typedef enum logic [2:0] {
		CLS_PSG,
		CLS_EXT,
		CLS_YM,
		CLS_END,
		CLS_DELAY
	} cls_t;

	// classified beat carried through the queue
	typedef struct packed {
		op_t        op;
		cls_t       cls;
		logic [7:0] data_byte;
	} fe_item_t;

endpackage

// ----- rtl/mrsi_front.sv -----
`timescale 1ns / 1ps
// front stage: accepts input beats, sorts the request and pre-classifies the byte
// depends on mrsi_pkg

module mrsi_front import mrsi_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     item_valid,
	output logic     item_ready,
	input  in_item_t item,
	output logic     push_valid,
	input  logic     push_ready,
	output fe_item_t push_data
);

	logic     valid_s1;
	fe_item_t item_s1;
	fe_item_t cls_item;

	always_comb begin
		cls_item.data_byte = item.in_byte;
		case (item.req_type)
			REQ_TICK:  cls_item.op = OP_TICK;
			REQ_BYTE:  cls_item.op = OP_BYTE;
			REQ_START: cls_item.op = OP_START;
			default:   cls_item.op = OP_NOP;
		endcase
		if (item.in_byte < CMD_EXT) begin
			cls_item.cls = CLS_PSG;
		end else if (item.in_byte == CMD_EXT) begin
			cls_item.cls = CLS_EXT;
		end else if (item.in_byte < CMD_END) begin
			cls_item.cls = CLS_YM;
		end else if (item.in_byte == CMD_END) begin
			cls_item.cls = CLS_END;
		end else begin
			cls_item.cls = CLS_DELAY;
		end
	end

	assign item_ready = !valid_s1 || push_ready;
	assign push_valid = valid_s1;
	assign push_data  = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_ready) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_ready && item_valid) begin
			item_s1 <= cls_item;
		end
	end

endmodule

// ----- rtl/mrsi_fifo.sv -----
`timescale 1ns / 1ps
// short queue of classified beats between the front and back stages
// depends on mrsi_pkg

module mrsi_fifo import mrsi_pkg::*; #(
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push_valid,
	output logic     push_ready,
	input  fe_item_t push_data,
	output logic     pop_valid,
	input  logic     pop_ready,
	output fe_item_t pop_data
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	fe_item_t        queue_q [DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [CW-1:0]   count_q;
	logic            push;
	logic            pop;

	assign push_ready = (count_q != CW'(DEPTH));
	assign pop_valid  = (count_q != '0);
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;
	assign pop_data   = queue_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			queue_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ----- rtl/mrsi_back.sv -----
`timescale 1ns / 1ps
// back stage: player state, command parser and the result register
// depends on mrsi_pkg

module mrsi_back import mrsi_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      pop_valid,
	output logic      pop_ready,
	input  fe_item_t  pop_data,
	output logic      result_valid,
	input  logic      result_ready,
	output out_item_t result
);

	typedef enum logic [5:0] {
		PH_CMD      = 6'b000001,
		PH_PSG_VAL  = 6'b000010,
		PH_EXT_CNT  = 6'b000100,
		PH_EXT_SKIP = 6'b001000,
		PH_YM_REG   = 6'b010000,
		PH_YM_VAL   = 6'b100000
	} phase_t;

	logic [6:0] delay_q;
	logic       playing_q;
	phase_t     phase_q;
	logic [7:0] held_reg_q;
	logic [5:0] left_q;
	logic       res_valid_q;
	out_item_t  res_q;

	logic [6:0] delay_d;
	logic       playing_d;
	phase_t     phase_d;
	logic [7:0] held_reg_d;
	logic [5:0] left_d;
	logic [5:0] left_dec;
	out_item_t  res_d;
	logic       pop;
	logic [7:0] b;

	assign pop_ready    = !res_valid_q || result_ready;
	assign pop          = pop_valid && pop_ready;
	assign result_valid = res_valid_q;
	assign result       = res_q;
	assign b            = pop_data.data_byte;
	assign left_dec     = left_q - 1'b1;

	always_comb begin
		delay_d    = delay_q;
		playing_d  = playing_q;
		phase_d    = phase_q;
		held_reg_d = held_reg_q;
		left_d     = left_q;
		res_d      = '0;
		case (pop_data.op)
			OP_START: begin
				delay_d   = 7'd1;
				playing_d = 1'b1;
				phase_d   = PH_CMD;
				left_d    = '0;
			end
			OP_TICK: begin
				if (delay_q != '0) begin
					delay_d = delay_q - 1'b1;
				end
			end
			OP_BYTE: begin
				if (playing_q && delay_q == '0) begin
					case (phase_q)
						PH_PSG_VAL: begin
							res_d.write_valid = 1'b1;
							res_d.write_chip  = CHIP_PSG;
							res_d.write_reg   = held_reg_q;
							res_d.write_value = b;
							phase_d           = PH_CMD;
						end
						PH_EXT_CNT: begin
							left_d  = b[5:0];
							phase_d = (b[5:0] != '0) ? PH_EXT_SKIP : PH_CMD;
						end
						PH_EXT_SKIP: begin
							left_d = left_dec;
							if (left_dec == '0) begin
								phase_d = PH_CMD;
							end
						end
						PH_YM_REG: begin
							held_reg_d = b;
							phase_d    = PH_YM_VAL;
						end
						PH_YM_VAL: begin
							res_d.write_valid = 1'b1;
							res_d.write_chip  = CHIP_YM;
							res_d.write_reg   = held_reg_q;
							res_d.write_value = b;
							left_d            = left_dec;
							phase_d           = (left_dec != '0) ? PH_YM_REG : PH_CMD;
						end
						default: begin
							phase_d = PH_CMD;
							case (pop_data.cls)
								CLS_PSG: begin
									held_reg_d = b & CNT_MASK;
									phase_d    = PH_PSG_VAL;
								end
								CLS_EXT: phase_d = PH_EXT_CNT;
								CLS_YM: begin
									left_d  = b[5:0];
									phase_d = PH_YM_REG;
								end
								CLS_END: playing_d = 1'b0;
								default: delay_d = b[6:0];
							endcase
						end
					endcase
				end else begin
					res_d.byte_ignored = 1'b1;
				end
			end
			default: ;
		endcase
		res_d.want_bytes = playing_d && (delay_d == '0);
		res_d.is_playing = playing_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delay_q     <= '0;
			playing_q   <= 1'b0;
			phase_q     <= PH_CMD;
			held_reg_q  <= '0;
			left_q      <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				delay_q    <= delay_d;
				playing_q  <= playing_d;
				phase_q    <= phase_d;
				held_reg_q <= held_reg_d;
				left_q     <= left_d;
			end
			if (pop_ready) begin
				res_valid_q <= pop_valid;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			res_q <= res_d;
		end
	end

endmodule

// ----- rtl/music_register_stream_interpreter_top.sv -----
`timescale 1ns / 1ps
// top level of the music register stream interpreter
// depends on mrsi_pkg, mrsi_front, mrsi_fifo, mrsi_back

// Turns a music command byte stream into PSG and YM register writes, paced by
// ticks. Every input beat (tick, stream byte or start) yields exactly one result
// beat carrying an optional register write plus the want_bytes, is_playing and
// byte_ignored status after that beat. The block takes one beat per clock cycle
// when the result side keeps up; the result beat is presented once its input beat
// has passed the front register, the queue and the result register, and up to
// QUEUE_DEPTH + 2 beats can be held while the result side stalls. The rate is set
// by the back stage's player state update, one beat per cycle unless results stall.

module music_register_stream_interpreter_top import mrsi_pkg::*; #(
	parameter int QUEUE_DEPTH_P = QUEUE_DEPTH
) (
	input  logic      clk,
	input  logic      arst_n,
	// input beats
	input  logic      item_valid,
	output logic      item_ready,
	input  in_item_t  item,
	// result beats
	output logic      result_valid,
	input  logic      result_ready,
	output out_item_t result
);

	// front to queue
	logic     fq_valid;
	logic     fq_ready;
	fe_item_t fq_data;

	// queue to back
	logic     qb_valid;
	logic     qb_ready;
	fe_item_t qb_data;

	// front: sorts the request and classifies the byte as a command
	mrsi_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.item       (item),
		.push_valid (fq_valid),
		.push_ready (fq_ready),
		.push_data  (fq_data)
	);

	// queue: lets the front keep taking beats while results are stalled
	mrsi_fifo #(
		.DEPTH (QUEUE_DEPTH_P)
	) u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (fq_valid),
		.push_ready (fq_ready),
		.push_data  (fq_data),
		.pop_valid  (qb_valid),
		.pop_ready  (qb_ready),
		.pop_data   (qb_data)
	);

	// back: delay counter, parse phase and the registered result
	mrsi_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.pop_valid    (qb_valid),
		.pop_ready    (qb_ready),
		.pop_data     (qb_data),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

	// a write happens only while playing with the delay expired
	a_write_while_wanted: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.write_valid |-> result.want_bytes && result.is_playing)
		else $error("register write outside of byte phase");

	// an ignored byte never issues a write
	a_ignored_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.byte_ignored |-> !result.write_valid)
		else $error("ignored byte produced a write");

	// want_bytes implies playback is active
	a_want_implies_play: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.want_bytes |-> result.is_playing)
		else $error("bytes wanted while not playing");

	// a beat leaving the queue always lands in the result register next cycle
	a_pop_fills_result: assert property (@(posedge clk) disable iff (!arst_n)
		qb_valid && qb_ready |=> result_valid)
		else $error("queue pop lost");

endmodule

// ----- sim/tb_top.sv -----
`timescale 1ns / 1ps
// self-checking testbench for music_register_stream_interpreter_top
// depends on mrsi_pkg and the rtl of the block; predicts every result beat in place

module tb_top;
	import mrsi_pkg::*;

	// parse state of the predicted player
	typedef enum logic [2:0] {
		ST_CMD,
		ST_PSG_VALUE,
		ST_EXT_COUNT,
		ST_EXT_SKIP,
		ST_YM_REG,
		ST_YM_VALUE
	} parse_st_t;

	// one row of the directed table: beat, and optionally a result typed in by hand
	typedef struct {
		in_item_t  beat;
		bit        pinned;
		out_item_t result;
	} row_t;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      item_valid = 1'b0;
	logic      item_ready;
	in_item_t  item = '0;
	logic      result_valid;
	logic      result_ready = 1'b0;
	out_item_t result;

	// hand-typed expectation that travels with the current input beat
	bit        row_pinned = 1'b0;
	out_item_t row_result = '0;

	// predicted player state
	logic [6:0] delay_left;
	logic       playing;
	parse_st_t  parse_st;
	logic [7:0] held_reg;
	logic [5:0] run_left;

	out_item_t pending_results[$];
	row_t      directed_rows[$];
	in_item_t  stream_beats[$];
	int        mismatch_count = 0;
	int        send_idle = 0;
	int        recv_idle = 0;
	bit        gen_playing = 1'b0;

	music_register_stream_interpreter_top dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

	always #5 clk = ~clk;

	// predicts the result beat of one accepted input beat and advances the player state
	function automatic out_item_t interpret_beat(in_item_t beat);
		out_item_t  r;
		logic [7:0] b;
		r = '0;
		b = beat.in_byte;
		case (beat.req_type)
			REQ_START: begin
				delay_left = 7'd1;
				playing = 1'b1;
				parse_st = ST_CMD;
				run_left = '0;
			end
			REQ_TICK: begin
				if (delay_left != 0)
					delay_left = delay_left - 7'd1;
			end
			REQ_BYTE: begin
				if (playing && delay_left == 0) begin
					case (parse_st)
						ST_PSG_VALUE: begin
							r.write_valid = 1'b1;
							r.write_chip = CHIP_PSG;
							r.write_reg = held_reg;
							r.write_value = b;
							parse_st = ST_CMD;
						end
						ST_EXT_COUNT: begin
							run_left = b[5:0];
							parse_st = (run_left != 0) ? ST_EXT_SKIP : ST_CMD;
						end
						ST_EXT_SKIP: begin
							run_left = run_left - 6'd1;
							if (run_left == 0)
								parse_st = ST_CMD;
						end
						ST_YM_REG: begin
							held_reg = b;
							parse_st = ST_YM_VALUE;
						end
						ST_YM_VALUE: begin
							r.write_valid = 1'b1;
							r.write_chip = CHIP_YM;
							r.write_reg = held_reg;
							r.write_value = b;
							run_left = run_left - 6'd1;
							parse_st = (run_left != 0) ? ST_YM_REG : ST_CMD;
						end
						default: begin
							parse_st = ST_CMD;
							if (b < CMD_EXT) begin
								held_reg = b & CNT_MASK;
								parse_st = ST_PSG_VALUE;
							end else if (b == CMD_EXT) begin
								parse_st = ST_EXT_COUNT;
							end else if (b < CMD_END) begin
								run_left = b[5:0];
								parse_st = ST_YM_REG;
							end else if (b == CMD_END) begin
								playing = 1'b0;
							end else begin
								delay_left = b[6:0] & DELAY_MASK[6:0];
							end
						end
					endcase
				end else begin
					r.byte_ignored = 1'b1;
				end
			end
			default: ;
		endcase
		r.want_bytes = playing && (delay_left == 0);
		r.is_playing = playing;
		return r;
	endfunction

	task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
		if (want !== got) begin
			$display("%0t ns: %s mismatch, expected %h actual %h", $time, name, want, got);
			mismatch_count++;
		end
	endtask

	// monitor: both handshakes are taken from the values just before the edge
	always @(posedge clk) begin : monitor
		out_item_t want_r;
		out_item_t pred_r;
		if (arst_n) begin
			if (result_valid && result_ready) begin
				if (pending_results.size() == 0) begin
					$display("%0t ns: result beat with nothing expected, actual %h",
						$time, result);
					mismatch_count++;
				end else begin
					want_r = pending_results.pop_front();
					check_field("write_valid", 8'(want_r.write_valid),
						8'(result.write_valid));
					check_field("write_chip", 8'(want_r.write_chip),
						8'(result.write_chip));
					check_field("write_reg", want_r.write_reg, result.write_reg);
					check_field("write_value", want_r.write_value, result.write_value);
					check_field("want_bytes", 8'(want_r.want_bytes),
						8'(result.want_bytes));
					check_field("is_playing", 8'(want_r.is_playing),
						8'(result.is_playing));
					check_field("byte_ignored", 8'(want_r.byte_ignored),
						8'(result.byte_ignored));
				end
			end
			if (item_valid && item_ready) begin
				// the predictor runs on every beat so its state stays in step
				pred_r = interpret_beat(item);
				pending_results.push_back(row_pinned ? row_result : pred_r);
			end
		end
	end

	// result side stalls at random, by the current percentage
	always @(posedge clk)
		result_ready <= ($urandom_range(0, 99) >= recv_idle);

	task automatic add_row(logic [1:0] req, logic [7:0] b, bit pinned, out_item_t r);
		row_t row;
		row.beat.req_type = req;
		row.beat.in_byte = b;
		row.pinned = pinned;
		row.result = r;
		directed_rows.push_back(row);
	endtask

	task automatic push_beat(logic [1:0] req, logic [7:0] b);
		in_item_t beat;
		beat.req_type = req;
		beat.in_byte = b;
		stream_beats.push_back(beat);
	endtask

	// mostly well-formed command phrases with random content, plus some noise
	task automatic build_stream(int count);
		int pick;
		int n;
		int d;
		while (stream_beats.size() < count) begin
			pick = $urandom_range(0, 99);
			if (!gen_playing) begin
				push_beat(REQ_START, 8'($urandom));
				push_beat(REQ_TICK, 8'($urandom));
				gen_playing = 1'b1;
			end else if (pick < 30) begin
				push_beat(REQ_BYTE, 8'($urandom_range(0, 8'h3f)));
				push_beat(REQ_BYTE, 8'($urandom));
			end else if (pick < 40) begin
				n = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 63) : $urandom_range(0, 3);
				push_beat(REQ_BYTE, CMD_EXT);
				push_beat(REQ_BYTE, {2'($urandom), 6'(n)});
				repeat (n) push_beat(REQ_BYTE, 8'($urandom));
			end else if (pick < 65) begin
				n = ($urandom_range(0, 19) == 0) ? $urandom_range(1, 63) : $urandom_range(1, 4);
				push_beat(REQ_BYTE, CMD_EXT | 8'(n));
				repeat (2 * n) push_beat(REQ_BYTE, 8'($urandom));
			end else if (pick < 80) begin
				d = ($urandom_range(0, 19) == 0) ? 127 : $urandom_range(1, 4);
				push_beat(REQ_BYTE, CMD_END | 8'(d));
				repeat (d + $urandom_range(0, 1)) push_beat(REQ_TICK, 8'($urandom));
			end else if (pick < 84) begin
				push_beat(REQ_BYTE, CMD_END);
				if ($urandom_range(0, 1))
					push_beat(REQ_BYTE, 8'($urandom));
				gen_playing = 1'b0;
			end else if (pick < 89) begin
				push_beat(REQ_TICK, 8'($urandom));
			end else if (pick < 93) begin
				push_beat(REQ_BYTE, 8'($urandom));
			end else if (pick < 95) begin
				push_beat(OP_NOP, 8'($urandom));
			end else if (pick < 97) begin
				// restart in the middle of whatever is being decoded
				push_beat(REQ_START, 8'($urandom));
				push_beat(REQ_TICK, 8'($urandom));
			end else begin
				push_beat(2'($urandom), 8'($urandom));
			end
		end
	endtask

	// drives one beat, idling first at random, and returns once it is accepted
	task automatic send_beat(in_item_t beat, bit pinned, out_item_t r);
		logic took;
		while ($urandom_range(0, 99) < send_idle) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item_valid <= 1'b1;
		item <= beat;
		row_pinned <= pinned;
		row_result <= r;
		do begin
			@(negedge clk);
			took = item_ready;
			@(posedge clk);
		end while (!took);
	endtask

	initial begin : stimulus
		row_t row;
		int   ph;
		delay_left = '0;
		playing = 1'b0;
		parse_st = ST_CMD;
		held_reg = '0;
		run_left = '0;

		// directed table; results typed in only where they are obvious
		add_row(REQ_TICK, 8'h00, 1, '0);
		add_row(REQ_BYTE, 8'hff, 1, out_item_t'{1'b0, 1'b0, 8'h00, 8'h00, 1'b0, 1'b0, 1'b1});
		add_row(OP_NOP, 8'haa, 1, '0);
		add_row(REQ_START, 8'h55, 1, out_item_t'{1'b0, 1'b0, 8'h00, 8'h00, 1'b0, 1'b1, 1'b0});
		// byte while the start delay is still pending
		add_row(REQ_BYTE, 8'h00, 1, out_item_t'{1'b0, 1'b0, 8'h00, 8'h00, 1'b0, 1'b1, 1'b1});
		add_row(REQ_TICK, 8'hff, 1, out_item_t'{1'b0, 1'b0, 8'h00, 8'h00, 1'b1, 1'b1, 1'b0});
		add_row(REQ_BYTE, 8'h00, 0, '0);
		// tick between a psg command and its value
		add_row(REQ_TICK, 8'h00, 0, '0);
		add_row(REQ_BYTE, 8'hff, 1,
			out_item_t'{1'b1, CHIP_PSG, 8'h00, 8'hff, 1'b1, 1'b1, 1'b0});
		add_row(REQ_BYTE, 8'h3f, 0, '0);
		add_row(REQ_BYTE, 8'h00, 0, '0);
		// extension with zero count, then with one skipped byte
		add_row(REQ_BYTE, CMD_EXT, 0, '0);
		add_row(REQ_BYTE, 8'h00, 0, '0);
		add_row(REQ_BYTE, CMD_EXT, 0, '0);
		add_row(REQ_BYTE, 8'hc1, 0, '0);
		add_row(REQ_BYTE, 8'h12, 0, '0);
		add_row(REQ_BYTE, 8'h41, 0, '0);
		add_row(REQ_BYTE, 8'hff, 0, '0);
		add_row(REQ_BYTE, 8'h00, 0, '0);
		// longest ym run, abandoned by a restart
		add_row(REQ_BYTE, 8'h7f, 0, '0);
		add_row(REQ_BYTE, 8'h55, 0, '0);
		add_row(REQ_START, 8'h00, 1, out_item_t'{1'b0, 1'b0, 8'h00, 8'h00, 1'b0, 1'b1, 1'b0});
		add_row(REQ_TICK, 8'h00, 0, '0);
		add_row(REQ_BYTE, 8'h81, 0, '0);
		add_row(REQ_TICK, 8'h00, 0, '0);
		// end of playback, then a byte that must be dropped
		add_row(REQ_BYTE, CMD_END, 1, '0);
		add_row(REQ_BYTE, 8'h12, 1, out_item_t'{1'b0, 1'b0, 8'h00, 8'h00, 1'b0, 1'b0, 1'b1});

		send_idle = 14;
		recv_idle = 48;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i]) begin
			row = directed_rows[i];
			send_beat(row.beat, row.pinned, row.result);
		end

		// three idling phases of random stream
		for (ph = 0; ph < 3; ph++) begin
			send_idle = (ph == 0) ? 14 : (ph == 1) ? 48 : 0;
			recv_idle = (ph == 0) ? 48 : (ph == 1) ? 14 : 0;
			build_stream(160);
			while (stream_beats.size() != 0)
				send_beat(stream_beats.pop_front(), 1'b0, '0);
		end

		item_valid <= 1'b0;
		recv_idle = 0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);

		if (mismatch_count == 0 && pending_results.size() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

	// watchdog against a hung handshake
	initial begin
		#3000000;
		$display("== FAIL ==");
		$finish;
	end

endmodule
